// ----- sv/v4alu_pkg.sv -----
`default_nettype none
package v4alu_pkg;
    localparam int DefFracBits = 16;
    localparam int DefLaneCount = 4;
    localparam int NumLanes = 4;
    localparam int DataW = 32;
    localparam int OpW = 4;
    // opcodes
    localparam logic [OpW-1:0] OP_ADD = 4'd0;
    localparam logic [OpW-1:0] OP_SUB = 4'd1;
    localparam logic [OpW-1:0] OP_MUL = 4'd2;
    localparam logic [OpW-1:0] OP_DIV = 4'd3;
    localparam logic [OpW-1:0] OP_ADDS = 4'd4;
    localparam logic [OpW-1:0] OP_SUBS = 4'd5;
    localparam logic [OpW-1:0] OP_MULS = 4'd6;
    localparam logic [OpW-1:0] OP_DIVS = 4'd7;
    localparam logic [OpW-1:0] OP_MAG = 4'd8;
    localparam logic [OpW-1:0] OP_NORM = 4'd9;
    // lane-level operation kinds
    typedef enum logic [1:0] {
        LK_ADD = 2'd0,
        LK_SUB = 2'd1,
        LK_MUL = 2'd2,
        LK_DIV = 2'd3
    } lane_kind_t;
    typedef struct packed {
        logic [OpW-1:0] op;
    } ctl_t;
endpackage
`default_nettype wire

// ----- sv/v4alu_if.sv -----
`default_nettype none
interface v4alu_in_if;
    logic valid;
    logic ready;
    logic [3:0] req_type;
    logic signed [31:0] a_lane0;
    logic signed [31:0] a_lane1;
    logic signed [31:0] a_lane2;
    logic signed [31:0] a_lane3;
    logic signed [31:0] b_lane0;
    logic signed [31:0] b_lane1;
    logic signed [31:0] b_lane2;
    logic signed [31:0] b_lane3;
    modport source (output valid, req_type, a_lane0, a_lane1, a_lane2, a_lane3,
        b_lane0, b_lane1, b_lane2, b_lane3, input ready);
    modport sink (input valid, req_type, a_lane0, a_lane1, a_lane2, a_lane3,
        b_lane0, b_lane1, b_lane2, b_lane3, output ready);
endinterface

interface v4alu_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] res_lane0;
    logic signed [31:0] res_lane1;
    logic signed [31:0] res_lane2;
    logic signed [31:0] res_lane3;
    logic error_flag;
    modport source (output valid, res_lane0, res_lane1, res_lane2, res_lane3,
        error_flag, input ready);
    modport sink (input valid, res_lane0, res_lane1, res_lane2, res_lane3,
        error_flag, output ready);
endinterface
`default_nettype wire

// ----- sv/v4alu_div.sv -----
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, 64-bit unsigned
// numerator over 33-bit divisor, full 64-bit quotient, tag carried alongside.
module v4alu_div
    import v4alu_pkg::*;
#(
    parameter int QW = 64,
    parameter int DW = 33,
    parameter int TW = 8
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [QW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [TW-1:0] tag_in,
    output logic [QW-1:0]      quo,
    output logic [TW-1:0]      tag_out
);
    // stage registers: partial remainder, quotient/remaining numerator, divisor
    logic [DW:0]   rem_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic [TW-1:0] t_reg   [QW+1];

    always_comb
    begin
        rem_reg[0] = '0;
        q_reg[0] = num;
        d_reg[0] = den;
        t_reg[0] = tag_in;
    end

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic [DW:0] sh;
        logic [DW:0] df;
        logic        ge;
        always_comb
        begin
            sh = {rem_reg[s][DW-1:0], q_reg[s][QW-1]};
            df = sh - {1'b0, d_reg[s]};
            ge = (sh >= {1'b0, d_reg[s]});
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? df : sh;
                q_reg[s+1] <= {q_reg[s][QW-2:0], ge};
                d_reg[s+1] <= d_reg[s];
                t_reg[s+1] <= t_reg[s];
            end
        end
    end

    assign quo = q_reg[QW];
    assign tag_out = t_reg[QW];
endmodule
`default_nettype wire

// ----- sv/v4alu_sqrt.sv -----
`default_nettype none
// Pipelined digit-by-digit integer square root, one result bit per stage.
module v4alu_sqrt
    import v4alu_pkg::*;
#(
    parameter int SW = 66
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [SW-1:0] rad,
    output logic [SW/2-1:0]    root
);
    localparam int RW = SW / 2;
    logic [SW-1:0] x_reg [RW+1];
    logic [RW+1:0] r_reg [RW+1];
    logic [RW-1:0] o_reg [RW+1];

    always_comb
    begin
        x_reg[0] = rad;
        r_reg[0] = '0;
        o_reg[0] = '0;
    end

    for (genvar s = 0; s < RW; s++) begin : g_st
        logic [RW+2:0] tr;
        logic [RW+2:0] tt;
        logic [RW+2:0] df;
        always_comb
        begin
            tr = {r_reg[s][RW:0], x_reg[s][SW-1 -: 2]};
            tt = {1'b0, o_reg[s], 2'b01};
            df = tr - tt;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s+1] <= {x_reg[s][SW-3:0], 2'b00};
                r_reg[s+1] <= (tr >= tt) ? df[RW+1:0] : tr[RW+1:0];
                o_reg[s+1] <= {o_reg[s][RW-2:0], tr >= tt};
            end
        end
    end
    assign root = o_reg[RW];
endmodule
`default_nettype wire

// ----- sv/v4alu_lane.sv -----
`default_nettype none
// One lane: add/sub/mul front end, shared divide for div and normalize.
// Operand prep register, the divider pipeline and a saturation register, advancing only while en is high.
module v4alu_lane
    import v4alu_pkg::*;
#(
    parameter int FracBits = DefFracBits
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire lane_kind_t        kind,
    input  wire logic              norm,
    input  wire logic signed [31:0] x,
    input  wire logic signed [31:0] y,
    input  wire logic [32:0]       mag,
    output logic [31:0]            res,
    output logic                   err
);
    localparam logic [32:0] PosMax = 33'h0_7FFF_FFFF;
    localparam logic [32:0] NegMag = 33'h0_8000_0000;

    // stage 1: operand prep, multiply, add
    logic [31:0] mx, my;
    logic        neg;
    always_comb
    begin
        mx = x[31] ? 32'(-x) : 32'(x);
        my = y[31] ? 32'(-y) : 32'(y);
        neg = norm ? x[31] : (x[31] != y[31]);
    end

    logic [63:0]  prod_reg;
    logic signed [32:0] sum_reg;
    logic [63:0]  num_reg;
    logic [32:0]  den_reg;
    logic [3:0]   meta_reg; // {kind, neg, xneg}
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mx * my;
            sum_reg <= (kind == LK_SUB) ? 33'(x) - 33'(y) : 33'(x) + 33'(y);
            num_reg <= 64'(mx) << FracBits;
            den_reg <= norm ? mag : {1'b0, my};
            meta_reg <= {norm ? LK_DIV : kind, neg, x[31]};
        end
    end

    // divide pipeline carries the other paths as tag
    localparam int TW = 64 + 33 + 4 + 1;
    logic [TW-1:0] tag_o;
    logic [63:0]   quo;
    logic [63:0]   mres;
    assign mres = (prod_reg + (64'd1 << (FracBits - 1))) >> FracBits;
    v4alu_div #(.QW(64), .DW(33), .TW(TW)) u_div (
        .clk(clk), .en(en),
        .num(num_reg), .den(den_reg),
        .tag_in({mres, sum_reg, meta_reg, den_reg == '0}),
        .quo(quo), .tag_out(tag_o)
    );

    logic [63:0] t_m;
    logic signed [32:0] t_s;
    lane_kind_t t_k;
    logic t_neg, t_xn, t_dz;
    assign {t_m, t_s} = tag_o[TW-1 -: 97];
    assign t_k = lane_kind_t'(tag_o[4:3]);
    assign t_neg = tag_o[2];
    assign t_xn = tag_o[1];
    assign t_dz = tag_o[0];

    // saturate by magnitude and sign
    function automatic logic [32:0] from_mag(input logic [63:0] m, input logic n);
        logic [32:0] r;
        if (n)
            r = (m > 64'(NegMag)) ? {1'b1, NegMag[31:0]} : {1'b0, 32'(-m)};
        else
            r = (m > 64'(PosMax)) ? {1'b1, PosMax[31:0]} : {1'b0, m[31:0]};
        return r;
    endfunction

    logic [32:0] fm;
    always_comb
    begin
        fm = '0;
        case (t_k)
            LK_ADD, LK_SUB:
            begin
                if (t_s > 33'sh0_7FFF_FFFF) fm = {1'b1, PosMax[31:0]};
                else if (t_s < -33'sh0_8000_0000) fm = {1'b1, NegMag[31:0]};
                else fm = {1'b0, t_s[31:0]};
            end
            LK_MUL: fm = from_mag(t_m, t_neg);
            LK_DIV:
            begin
                if (t_dz) fm = {1'b1, t_xn ? NegMag[31:0] : PosMax[31:0]};
                else fm = from_mag(quo, t_neg);
            end
            default: fm = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res <= fm[31:0];
            err <= fm[32];
        end
    end
endmodule
`default_nettype wire

// ----- sv/vec4_alu_with_normalize_unit.sv -----
`default_nettype none
// Four-lane signed Q16.16 vector ALU. Fully pipelined: one beat accepted per
// cycle while the output holding register is empty. A beat passes two
// squaring/summing stages, a 33-stage square root for magnitude, then 66 lane
// stages: operand prep, a 64-stage divider and a saturation register. Every
// opcode takes the same path length, so results leave in order. A result beat
// that the sink does not take is parked in an output holding register; the
// pipeline and the input stall only while that register is full, so
// in_ch.ready is registered and does not depend on out_ch.ready.
module vec4_alu_with_normalize_unit
    import v4alu_pkg::*;
#(
    parameter int FracBits = DefFracBits,
    parameter int LaneCount = DefLaneCount
) (
    input wire logic clk,
    input wire logic rst_n,
    v4alu_in_if.sink   in_ch,
    v4alu_out_if.source out_ch
);
    localparam int SqLat = 33;
    localparam int LaneLat = 66;
    localparam int Lat = 2 + SqLat + LaneLat;

    logic en;
    logic hold_reg;
    logic pipe_vld;
    assign en = !hold_reg;
    assign in_ch.ready = en;

    logic [31:0] a_in [NumLanes];
    logic [31:0] b_in [NumLanes];
    assign a_in[0] = in_ch.a_lane0; assign a_in[1] = in_ch.a_lane1;
    assign a_in[2] = in_ch.a_lane2; assign a_in[3] = in_ch.a_lane3;
    assign b_in[0] = in_ch.b_lane0; assign b_in[1] = in_ch.b_lane1;
    assign b_in[2] = in_ch.b_lane2; assign b_in[3] = in_ch.b_lane3;

    // valid shift line
    logic [Lat-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Lat-2:0], in_ch.valid};
    end
    assign pipe_vld = vld_reg[Lat-1];

    // stage 1: squares; stage 2: sum (66 bits)
    logic [63:0] sq_reg [NumLanes];
    logic [31:0] a1_reg [NumLanes];
    logic [31:0] b1_reg [NumLanes];
    ctl_t c1_reg;
    for (genvar i = 0; i < NumLanes; i++) begin : g_sq
        logic [31:0] m;
        assign m = a_in[i][31] ? 32'(-a_in[i]) : a_in[i];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[i] <= (i < LaneCount) ? m * m : '0;
                a1_reg[i] <= a_in[i];
                b1_reg[i] <= b_in[i];
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
            c1_reg.op <= in_ch.req_type;
    end

    logic [65:0] ss_reg;
    logic [31:0] a2_reg [NumLanes];
    logic [31:0] b2_reg [NumLanes];
    ctl_t c2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg <= 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]) + 66'(sq_reg[3]);
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
        end
    end

    // square root with matching delay lines for operands
    logic [32:0] root;
    v4alu_sqrt #(.SW(66)) u_sqrt (.clk(clk), .en(en), .rad(ss_reg), .root(root));
    logic [31:0] ad_reg [SqLat+1][NumLanes];
    logic [31:0] bd_reg [SqLat+1][NumLanes];
    ctl_t        cd_reg [SqLat+1];
    always_comb
    begin
        ad_reg[0] = a2_reg;
        bd_reg[0] = b2_reg;
        cd_reg[0] = c2_reg;
    end
    for (genvar s = 0; s < SqLat; s++) begin : g_dl
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ad_reg[s+1] <= ad_reg[s];
                bd_reg[s+1] <= bd_reg[s];
                cd_reg[s+1] <= cd_reg[s];
            end
        end
    end
    logic [31:0] a3 [NumLanes];
    logic [31:0] b3 [NumLanes];
    ctl_t c3;
    assign a3 = ad_reg[SqLat];
    assign b3 = bd_reg[SqLat];
    assign c3 = cd_reg[SqLat];

    // lanes
    logic is_norm, is_vec, scal;
    lane_kind_t kind;
    assign is_norm = (c3.op == OP_NORM);
    assign is_vec = (c3.op <= OP_DIVS);
    assign scal = (c3.op >= OP_ADDS) && is_vec;
    assign kind = lane_kind_t'(c3.op[1:0]);

    logic [31:0] lres [NumLanes];
    logic        lerr [NumLanes];
    for (genvar i = 0; i < NumLanes; i++) begin : g_lane
        v4alu_lane #(.FracBits(FracBits)) u_lane (
            .clk(clk), .en(en), .kind(kind), .norm(is_norm),
            .x(a3[i]), .y(scal ? b3[0] : b3[i]), .mag(root),
            .res(lres[i]), .err(lerr[i])
        );
    end

    // side path for op, root and zero check
    ctl_t        ce_reg [LaneLat+1];
    logic [32:0] re_reg [LaneLat+1];
    always_comb
    begin
        ce_reg[0] = c3;
        re_reg[0] = root;
    end
    for (genvar s = 0; s < LaneLat; s++) begin : g_sd
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ce_reg[s+1] <= ce_reg[s];
                re_reg[s+1] <= re_reg[s];
            end
        end
    end

    // merge
    ctl_t cf;
    logic [32:0] rf;
    assign cf = ce_reg[LaneLat];
    assign rf = re_reg[LaneLat];
    logic [31:0] o [NumLanes];
    logic oe;
    always_comb
    begin
        oe = 1'b0;
        for (int i = 0; i < NumLanes; i++)
        begin
            o[i] = '0;
        end
        if (cf.op <= OP_DIVS || (cf.op == OP_NORM && rf != '0))
        begin
            for (int i = 0; i < NumLanes; i++)
            begin
                if (i < LaneCount)
                begin
                    o[i] = lres[i];
                    oe = oe | lerr[i];
                end
            end
        end
        else if (cf.op == OP_NORM)
            oe = 1'b1;
        else if (cf.op == OP_MAG)
        begin
            o[0] = rf[32] ? 32'h7FFF_FFFF : rf[31:0];
            oe = rf[32] | rf[31];
            if (rf[31]) o[0] = 32'h7FFF_FFFF;
        end
    end

    // output holding register: parks a beat the sink has not taken
    logic [31:0] hold_lane_reg [NumLanes];
    logic        hold_err_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else if (hold_reg)
        begin
            if (out_ch.ready)
                hold_reg <= 1'b0;
        end
        else if (pipe_vld && !out_ch.ready)
            hold_reg <= 1'b1;
    end
    always_ff @(posedge clk)
    begin
        if (!hold_reg)
        begin
            hold_lane_reg <= o;
            hold_err_reg <= oe;
        end
    end

    assign out_ch.valid = hold_reg | pipe_vld;
    assign out_ch.res_lane0 = hold_reg ? hold_lane_reg[0] : o[0];
    assign out_ch.res_lane1 = hold_reg ? hold_lane_reg[1] : o[1];
    assign out_ch.res_lane2 = hold_reg ? hold_lane_reg[2] : o[2];
    assign out_ch.res_lane3 = hold_reg ? hold_lane_reg[3] : o[3];
    assign out_ch.error_flag = hold_reg ? hold_err_reg : oe;

    // checks on beats leaving straight from the pipeline, and on stalls
    a_nomag: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld && !hold_reg && cf.op == OP_MAG |-> out_ch.res_lane1 == '0)
        else $error("magnitude lane 1 not zero");
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld && !hold_reg && cf.op > OP_NORM |-> !out_ch.error_flag)
        else $error("unused opcode flagged");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result lost under stall");
endmodule
`default_nettype wire

// ----- verif/v4alu_tb_pkg.sv -----
package v4alu_tb_pkg;
    import v4alu_pkg::*;

    // one input beat
    typedef struct {
        logic [OpW-1:0]   op;
        logic [DataW-1:0] a [NumLanes];
        logic [DataW-1:0] b [NumLanes];
    } vec_req_t;

    // one result beat
    typedef struct {
        logic [DataW-1:0] lane [NumLanes];
        logic             err;
    } vec_res_t;
endpackage

// ----- verif/v4alu_checker.sv -----
module v4alu_checker
    import v4alu_pkg::*;
    import v4alu_tb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    v4alu_in_if.sink  in_mon,
    v4alu_out_if.sink out_mon,
    output int        fail_count,
    output int        pending
);
    localparam int Frac = DefFracBits;
    localparam logic [63:0] PosMax = 64'h7FFF_FFFF;
    localparam logic [63:0] NegMag = 64'h8000_0000;

    vec_res_t expected_q [$];

    // clamp a signed wide value to 32 bits
    function automatic logic [31:0] clamp_wide(input logic signed [63:0] v, inout logic err);
        if (v > $signed(PosMax)) begin err = 1'b1; return PosMax[31:0]; end
        if (v < -$signed(NegMag)) begin err = 1'b1; return NegMag[31:0]; end
        return v[31:0];
    endfunction

    // magnitude plus sign back to 32-bit signed
    function automatic logic [31:0] signed_from_mag(input logic [63:0] m, input logic neg,
                                                    inout logic err);
        if (neg) begin
            if (m > NegMag) begin err = 1'b1; return NegMag[31:0]; end
            return 32'(-m);
        end
        if (m > PosMax) begin err = 1'b1; return PosMax[31:0]; end
        return m[31:0];
    endfunction

    function automatic logic [63:0] abs_of(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // floor of the root of the exact sum of squares (fits in 66 bits)
    function automatic logic [63:0] vec_length(input logic [31:0] a [NumLanes]);
        logic [65:0] sum;
        logic [65:0] rem;
        logic [65:0] root;
        logic [65:0] bitv;
        sum = '0;
        for (int i = 0; i < DefLaneCount; i++)
            sum += 66'(abs_of(64'(signed'(a[i])))) * 66'(abs_of(64'(signed'(a[i]))));
        rem = sum;
        root = '0;
        bitv = 66'd1 << 64;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root[63:0];
    endfunction

    function automatic logic [31:0] lane_calc(input lane_kind_t kind, input logic [31:0] x,
                                              input logic [31:0] y, inout logic err);
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic [63:0] mx;
        logic [63:0] my;
        logic neg;
        sx = 64'(signed'(x));
        sy = 64'(signed'(y));
        mx = abs_of(sx);
        my = abs_of(sy);
        neg = (sx < 0) != (sy < 0);
        case (kind)
            LK_ADD: return clamp_wide(sx + sy, err);
            LK_SUB: return clamp_wide(sx - sy, err);
            LK_MUL: return signed_from_mag((mx * my + (64'd1 << (Frac - 1))) >> Frac, neg, err);
            default:
            begin
                if (my == 0) begin
                    err = 1'b1;
                    return sx < 0 ? NegMag[31:0] : PosMax[31:0];
                end
                return signed_from_mag((mx << Frac) / my, neg, err);
            end
        endcase
    endfunction

    function automatic vec_res_t alu_result(input vec_req_t r);
        vec_res_t res;
        logic [63:0] len;
        logic err;
        err = 1'b0;
        for (int i = 0; i < NumLanes; i++) res.lane[i] = '0;
        if (r.op <= OP_DIVS) begin
            for (int i = 0; i < DefLaneCount; i++)
                res.lane[i] = lane_calc(lane_kind_t'(r.op[1:0]), r.a[i],
                                        r.op >= OP_ADDS ? r.b[0] : r.b[i], err);
        end else if (r.op == OP_MAG) begin
            res.lane[0] = signed_from_mag(vec_length(r.a), 1'b0, err);
        end else if (r.op == OP_NORM) begin
            len = vec_length(r.a);
            if (len == 0) begin
                err = 1'b1;
            end else begin
                for (int i = 0; i < DefLaneCount; i++)
                    res.lane[i] = signed_from_mag((abs_of(64'(signed'(r.a[i]))) << Frac) / len,
                                                  r.a[i][31], err);
            end
        end
        res.err = err;
        return res;
    endfunction

    // predict on accepted input beats, compare on accepted output beats
    always @(posedge clk or negedge rst_n)
    begin
        vec_req_t req;
        vec_res_t got;
        vec_res_t want;
        int errs;
        if (!rst_n) begin
            fail_count <= 0;
            pending <= 0;
            expected_q.delete();
        end else begin
            errs = 0;
            if (in_mon.valid && in_mon.ready) begin
                req.op = in_mon.req_type;
                req.a[0] = in_mon.a_lane0; req.a[1] = in_mon.a_lane1;
                req.a[2] = in_mon.a_lane2; req.a[3] = in_mon.a_lane3;
                req.b[0] = in_mon.b_lane0; req.b[1] = in_mon.b_lane1;
                req.b[2] = in_mon.b_lane2; req.b[3] = in_mon.b_lane3;
                expected_q.push_back(alu_result(req));
            end
            if (out_mon.valid && out_mon.ready) begin
                got.lane[0] = out_mon.res_lane0; got.lane[1] = out_mon.res_lane1;
                got.lane[2] = out_mon.res_lane2; got.lane[3] = out_mon.res_lane3;
                got.err = out_mon.error_flag;
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    for (int i = 0; i < NumLanes; i++)
                        if (got.lane[i] !== want.lane[i]) begin
                            $error("res_lane%0d: expected %h, got %h", i, want.lane[i],
                                   got.lane[i]);
                            errs++;
                        end
                    if (got.err !== want.err) begin
                        $error("error_flag: expected %b, got %b", want.err, got.err);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_q.size();
        end
    end
endmodule

// ----- verif/tb.sv -----
module tb;
    import v4alu_pkg::*;
    import v4alu_tb_pkg::*;

    localparam int PipeDepth = 101;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    v4alu_in_if  in_ch ();
    v4alu_out_if out_ch ();

    vec4_alu_with_normalize_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    v4alu_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch.sink),
        .out_mon    (out_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // operand values weighted towards edges and small Q16.16 numbers
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
            4, 5: return 32'(signed'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            6: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // send one beat; valid stays high across back-to-back beats
    task automatic send_beat(input vec_req_t r);
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= r.op;
        in_ch.a_lane0 <= r.a[0]; in_ch.a_lane1 <= r.a[1];
        in_ch.a_lane2 <= r.a[2]; in_ch.a_lane3 <= r.a[3];
        in_ch.b_lane0 <= r.b[0]; in_ch.b_lane1 <= r.b[1];
        in_ch.b_lane2 <= r.b[2]; in_ch.b_lane3 <= r.b[3];
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_with_gap(input vec_req_t r);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        send_beat(r);
    endtask

    function automatic vec_req_t make_req(input logic [3:0] op, input logic [31:0] a0,
                                          input logic [31:0] a1, input logic [31:0] a2,
                                          input logic [31:0] a3, input logic [31:0] b0,
                                          input logic [31:0] b1, input logic [31:0] b2,
                                          input logic [31:0] b3);
        vec_req_t r;
        r.op = op;
        r.a[0] = a0; r.a[1] = a1; r.a[2] = a2; r.a[3] = a3;
        r.b[0] = b0; r.b[1] = b1; r.b[2] = b2; r.b[3] = b3;
        return r;
    endfunction

    // receiver back-pressure
    initial
    begin
        int g;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 99) < 20) begin
                g = $urandom_range(0, 9) == 0 ? $urandom_range(10, 50) : $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? 80 : $urandom_range(1, 6)) @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        vec_req_t r;
        int wait_cnt;
        in_ch.valid = 1'b0;
        in_ch.req_type = '0;
        {in_ch.a_lane0, in_ch.a_lane1, in_ch.a_lane2, in_ch.a_lane3} = '0;
        {in_ch.b_lane0, in_ch.b_lane1, in_ch.b_lane2, in_ch.b_lane3} = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode, extremes, divide by zero, zero vector, unused opcodes
        for (int op = 0; op <= 9; op++)
            send_beat(make_req(4'(op), 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                               32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                               32'h0002_8000));
        send_beat(make_req(OP_DIV, 32'h0003_0000, 32'hFFFD_0000, 0, 32'h8000_0000,
                           0, 0, 0, 0));
        send_beat(make_req(OP_DIVS, 32'h0001_0000, 32'hFFFF_0000, 0, 5,
                           0, 1, 1, 1));
        send_beat(make_req(OP_NORM, 0, 0, 0, 0, 1, 2, 3, 4));
        send_beat(make_req(OP_MAG, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_req(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 0, 0, 0, 0));
        send_beat(make_req(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 0, 0, 0, 0));
        send_beat(make_req(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_req(OP_MUL, 32'h0000_8000, 32'hFFFF_8000, 1, 32'hFFFF_FFFF,
                           32'h0000_0001, 32'h0000_0001, 32'h0000_8000, 32'h0000_8000));
        send_beat(make_req(4'd10, 1, 2, 3, 4, 5, 6, 7, 8));
        send_beat(make_req(4'd15, -1, -1, -1, -1, -1, -1, -1, -1));
        send_beat(make_req(OP_SUBS, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1,
                           32'h0000_0001, 0, 0, 0));

        // hold off until the pipeline has drained
        in_ch.valid <= 1'b0;
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000) begin
            @(posedge clk);
            wait_cnt++;
        end

        // random part
        for (int n = 0; n < 900; n++) begin
            r.op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            for (int i = 0; i < NumLanes; i++) begin
                r.a[i] = rand_operand();
                r.b[i] = rand_operand();
            end
            if ($urandom_range(0, 3) == 0) send_beat(r);
            else send_with_gap(r);
        end
        in_ch.valid <= 1'b0;

        // drain
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 50000) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (PipeDepth + 20) @(posedge clk);
        if (fail_count == 0 && pending == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("tb failed");
        $finish;
    end
endmodule
